>>> sv/integer_width_normalizer_defines.svh
// Assertion helpers for the normaliser RTL.
`ifndef INTEGER_WIDTH_NORMALIZER_DEFINES_SVH
`define INTEGER_WIDTH_NORMALIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IWN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IWN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/iwn_pkg.sv
package iwn_pkg;

  localparam int MAX_BYTES_DEF = 16;
  localparam int LEN_W         = 5;
  localparam int DECL_W        = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int SRC_LEN_W     = 8;
  localparam int WORD_W        = 64;
  localparam int IN_DATA_W     = 136;
  localparam int OUT_DATA_W    = 136;
  localparam int OUT_USER_W    = 4;

  localparam logic [DECL_W-1:0] DECLARED_RESET = 16'd1;
  localparam logic              TSIGNED_RESET  = 1'b1;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DECLARED_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIGNED  = 8'd1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SRC_LEN  = 3'd1,
    ST_BAD_DECLARED = 3'd2,
    ST_NEG_UNSIGNED = 3'd3,
    ST_NO_FIT       = 3'd4
  } status_t;

  // what one byte lane reports to the merge stage
  typedef struct packed {
    logic [7:0] data;
    logic       in_copy;    // below both source length and target width
    logic       in_target;  // below target width
    logic       dropped;    // in [target width, source length)
    logic       is_zero;
    logic       is_ones;
    logic       src_top;    // top source byte
    logic       tgt_top;    // top target byte, inside the source
  } lane_info_t;

  typedef struct packed {
    logic bad_slen;
    logic ssig;
  } item_ctrl_t;

endpackage

>>> sv/iwn_lane.sv
module iwn_lane #(
  parameter int LANE = 0
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [7:0]                 src_byte,
  input  logic [iwn_pkg::LEN_W-1:0]  slen,
  input  logic [iwn_pkg::LEN_W-1:0]  tlen,
  output iwn_pkg::lane_info_t        info
);
  import iwn_pkg::*;

  localparam logic [LEN_W-1:0] IDX     = LEN_W'(LANE);
  localparam logic [LEN_W-1:0] IDX_INC = LEN_W'(LANE + 1);

  lane_info_t info_next;

  always_comb begin
    info_next.data      = src_byte;
    info_next.in_copy   = (IDX < slen) && (IDX < tlen);
    info_next.in_target = IDX < tlen;
    info_next.dropped   = (IDX >= tlen) && (IDX < slen);
    info_next.is_zero   = src_byte == BYTE_ZERO;
    info_next.is_ones   = src_byte == BYTE_ONES;
    info_next.src_top   = IDX_INC == slen;
    info_next.tgt_top   = (IDX_INC == tlen) && (IDX < slen);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      info <= info_next;
    end
  end

endmodule

>>> sv/iwn_merge.sv
module iwn_merge #(
  parameter int MAX_BYTES = iwn_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  iwn_pkg::lane_info_t         lanes [MAX_BYTES],
  input  iwn_pkg::item_ctrl_t         ctrl,
  input  logic [iwn_pkg::DECL_W-1:0]  declared_bytes,
  input  logic                        target_signed,
  output iwn_pkg::status_t            status,
  output logic [2*iwn_pkg::WORD_W-1:0] result_data,
  output logic [iwn_pkg::LEN_W-1:0]   result_length,
  output logic                        result_signed
);
  import iwn_pkg::*;

  logic [MAX_BYTES-1:0]   drop_zero_ok;
  logic [MAX_BYTES-1:0]   drop_ones_ok;
  logic [MAX_BYTES-1:0]   src_msb_hit;
  logic [MAX_BYTES-1:0]   tgt_msb_hit;
  logic [MAX_BYTES*8-1:0] dst;
  logic                   bad_decl;
  logic                   neg;
  logic                   tgt_msb;
  logic                   fits_zero;
  logic                   fits_ones;
  logic [7:0]             fill;
  status_t                status_next;

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      drop_zero_ok[i] = !lanes[i].dropped || lanes[i].is_zero;
      drop_ones_ok[i] = !lanes[i].dropped || lanes[i].is_ones;
      src_msb_hit[i]  = lanes[i].src_top && lanes[i].data[7];
      tgt_msb_hit[i]  = lanes[i].tgt_top && lanes[i].data[7];
    end
    bad_decl  = (declared_bytes == '0) || (declared_bytes > DECL_W'(MAX_BYTES));
    neg       = ctrl.ssig && (|src_msb_hit);
    tgt_msb   = |tgt_msb_hit;
    fits_zero = &drop_zero_ok;
    fits_ones = &drop_ones_ok;
    fill      = (target_signed && neg) ? BYTE_ONES : BYTE_ZERO;

    for (int i = 0; i < MAX_BYTES; i++) begin
      if (!lanes[i].in_target) begin
        dst[i*8 +: 8] = BYTE_ZERO;
      end else if (lanes[i].in_copy) begin
        dst[i*8 +: 8] = lanes[i].data;
      end else begin
        dst[i*8 +: 8] = fill;
      end
    end

    status_next = ST_OK;
    if (ctrl.bad_slen) begin
      status_next = ST_BAD_SRC_LEN;
    end else if (bad_decl) begin
      status_next = ST_BAD_DECLARED;
    end else if (target_signed) begin
      if (ctrl.ssig) begin
        // dropped bytes must repeat the sign of the new top byte
        if (tgt_msb ? !fits_ones : !fits_zero) begin
          status_next = ST_NO_FIT;
        end
      end else if (!fits_zero || tgt_msb) begin
        status_next = ST_NO_FIT;
      end
    end else if (neg) begin
      status_next = ST_NEG_UNSIGNED;
    end else if (!fits_zero) begin
      status_next = ST_NO_FIT;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      if (status_next == ST_OK) begin
        result_data   <= (2*WORD_W)'(dst);
        result_length <= declared_bytes[LEN_W-1:0];
        result_signed <= target_signed;
      end else begin
        result_data   <= '0;
        result_length <= '0;
        result_signed <= 1'b0;
      end
    end
  end

endmodule

>>> sv/integer_width_normalizer.sv
// Channel   Dir  Fields (lowest bit up)
// s_*       in   tdata: value_low, value_high, source_length; tuser: source_signed
// m_*       out  tdata: result_low, result_high, result_length; tuser: status, result_signed
// cfg_*     in   index 0 declared_bytes, index 1 target_signed
//
// One request per cycle while m_tready holds; lane register, then merge register.
// Byte lanes compare in parallel; the merge stage reduces lane flags and picks status.
// rst is synchronous: empties both stages, declared_bytes back to 1, target_signed to 1.
// A stalled m_tready backs up through both stages; s_tready drops only when both are full.
module integer_width_normalizer #(
  parameter int MAX_BYTES = iwn_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [iwn_pkg::IN_DATA_W-1:0]   s_tdata,  // value_low, value_high, source_length
  input  logic                            s_tuser,  // source_signed
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [iwn_pkg::OUT_DATA_W-1:0]  m_tdata,  // result_low, result_high, result_length
  output logic [iwn_pkg::OUT_USER_W-1:0]  m_tuser,  // status, result_signed
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iwn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iwn_pkg::DECL_W-1:0]      cfg_data
);
  import iwn_pkg::*;
  `include "integer_width_normalizer_defines.svh"

  logic [DECL_W-1:0]    declared_bytes;
  logic                 target_signed;
  logic                 a_valid;
  logic                 a_ready;
  logic                 b_ready;
  logic                 in_fire;
  logic [SRC_LEN_W-1:0] slen_in;
  logic [LEN_W-1:0]     slen_lane;
  logic [LEN_W-1:0]     tlen_lane;
  item_ctrl_t           ctrl_next;
  item_ctrl_t           ctrl;
  lane_info_t           lanes [MAX_BYTES];
  status_t              status;
  logic [2*WORD_W-1:0]  result_data;
  logic [LEN_W-1:0]     result_length;
  logic                 result_signed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      declared_bytes <= DECLARED_RESET;
      target_signed  <= TSIGNED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DECLARED_BYTES: declared_bytes <= cfg_data;
        CFG_TARGET_SIGNED:  target_signed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign b_ready   = !m_tvalid || m_tready;
  assign a_ready   = !a_valid || b_ready;
  assign s_tready  = a_ready;
  assign in_fire   = s_tvalid && a_ready;
  assign slen_in   = s_tdata[2*WORD_W +: SRC_LEN_W];
  assign slen_lane = slen_in[LEN_W-1:0];
  assign tlen_lane = declared_bytes[LEN_W-1:0];

  always_comb begin
    ctrl_next.bad_slen = (slen_in == '0) || (slen_in > SRC_LEN_W'(MAX_BYTES));
    ctrl_next.ssig     = s_tuser;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= s_tvalid;
      end
      if (b_ready) begin
        m_tvalid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctrl <= ctrl_next;
    end
  end

  for (genvar g = 0; g < MAX_BYTES; g++) begin : g_lane
    iwn_lane #(
      .LANE (g)
    ) u_lane (
      .clk      (clk),
      .load     (in_fire),
      .src_byte (s_tdata[g*8 +: 8]),
      .slen     (slen_lane),
      .tlen     (tlen_lane),
      .info     (lanes[g])
    );
  end

  iwn_merge #(
    .MAX_BYTES (MAX_BYTES)
  ) u_merge (
    .clk            (clk),
    .load           (a_valid && b_ready),
    .lanes          (lanes),
    .ctrl           (ctrl),
    .declared_bytes (declared_bytes),
    .target_signed  (target_signed),
    .status         (status),
    .result_data    (result_data),
    .result_length  (result_length),
    .result_signed  (result_signed)
  );

  assign m_tdata = {3'b000, result_length, result_data};
  assign m_tuser = {result_signed, status};

  `IWN_ASSERT_NOW(a_err_zero, m_tvalid && status != ST_OK,
    result_data == '0 && result_length == '0 && !result_signed,
    "error result carries non-zero payload")
  `IWN_ASSERT_NOW(a_ok_len, m_tvalid && status == ST_OK,
    result_length != '0 && result_length <= LEN_W'(MAX_BYTES),
    "ok result with length outside 1..MAX_BYTES")
  `IWN_ASSERT_NEXT(a_stage_hold, a_valid && !b_ready, a_valid,
    "lane stage dropped a request while merge was stalled")
  `IWN_ASSERT_NEXT(a_out_load, a_valid && b_ready, m_tvalid,
    "merge stage missed a request from the lanes")

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iwn_pkg::*;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  slen;
    logic        ssig;
  } source_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic        sgn;
  } stored_t;

  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;
  localparam logic [63:0] ONES64 = {64{1'b1}};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DECL_W-1:0]     cfg_data;

  // column settings as the block should hold them
  logic [DECL_W-1:0] col_width;
  logic              col_signed;

  source_t source_q[$];
  stored_t resized_q[$];
  source_t on_bus;
  stored_t seen;
  stored_t want;
  int unsigned src_gap, snk_gap;
  bit src_quiet, snk_quiet;
  int errors;
  int stall_cnt;

  integer_width_normalizer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic stored_t resize_value(source_t s, logic [DECL_W-1:0] width, logic tsig);
    logic [7:0] sb [16];
    logic [7:0] db [16];
    stored_t r;
    int n, t, i;
    logic neg;
    logic [7:0] fill, ext;
    r = '{status: ST_OK, lo: '0, hi: '0, len: '0, sgn: 1'b0};
    fill = BYTE_ZERO;
    for (i = 0; i < 8; i++) begin
      sb[i] = s.lo[8*i +: 8];
      sb[i+8] = s.hi[8*i +: 8];
      db[i] = BYTE_ZERO;
      db[i+8] = BYTE_ZERO;
    end
    n = s.slen;
    t = width;
    if (n < 1 || n > 16) begin
      r.status = ST_BAD_SRC_LEN;
      return r;
    end
    if (t < 1 || t > 16) begin
      r.status = ST_BAD_DECLARED;
      return r;
    end
    neg = s.ssig && sb[n-1][7];
    if (tsig) begin
      if (s.ssig) begin
        ext = sb[t-1][7] ? BYTE_ONES : BYTE_ZERO;
        for (i = t; i < n; i++)
          if (sb[i] != ext) r.status = ST_NO_FIT;
        fill = neg ? BYTE_ONES : BYTE_ZERO;
      end else begin
        for (i = t; i < n; i++)
          if (sb[i] != BYTE_ZERO) r.status = ST_NO_FIT;
        // unsigned into signed: top target byte must leave the sign bit clear
        if (t <= n && sb[t-1][7]) r.status = ST_NO_FIT;
      end
    end else if (neg) begin
      r.status = ST_NEG_UNSIGNED;
    end else begin
      for (i = t; i < n; i++)
        if (sb[i] != BYTE_ZERO) r.status = ST_NO_FIT;
    end
    if (r.status != ST_OK) return r;
    for (i = 0; i < t; i++)
      db[i] = (i < n) ? sb[i] : fill;
    for (i = 0; i < 8; i++) begin
      r.lo[8*i +: 8] = db[i];
      r.hi[8*i +: 8] = db[i+8];
    end
    r.len = t[4:0];
    r.sgn = tsig;
    return r;
  endfunction

  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // mostly sign/zero extended values with a random number of significant bytes,
  // some with a flipped bit anywhere in the source bytes, a few with any length at all
  function automatic source_t random_source();
    source_t s;
    logic [7:0] b [16];
    int k, i;
    logic [7:0] ext;
    s.lo = {$urandom, $urandom};
    s.hi = {$urandom, $urandom};
    s.ssig = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) begin
      s.slen = 8'($urandom_range(0, 255));
      return s;
    end
    s.slen = 8'($urandom_range(1, 16));
    k = $urandom_range(1, $urandom_range(1, s.slen));
    ext = (s.ssig && $urandom_range(0, 1)) ? BYTE_ONES : BYTE_ZERO;
    for (i = 0; i < 8; i++) begin
      b[i] = s.lo[8*i +: 8];
      b[i+8] = s.hi[8*i +: 8];
    end
    for (i = k; i < s.slen; i++)
      b[i] = ext;
    if ($urandom_range(0, 3) != 0) b[k-1][7] = ext[7];
    if ($urandom_range(0, 4) == 0) begin
      i = $urandom_range(0, s.slen - 1);
      b[i] = b[i] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (i = 0; i < 8; i++) begin
      s.lo[8*i +: 8] = b[i];
      s.hi[8*i +: 8] = b[i+8];
    end
    return s;
  endfunction

  task automatic push_source(logic [63:0] lo, logic [63:0] hi, logic [7:0] slen, logic ssig);
    source_t s;
    s = '{lo: lo, hi: hi, slen: slen, ssig: ssig};
    source_q.insert(source_q.size(), s);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (source_q.size() != 0 || s_tvalid || resized_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DECL_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DECLARED_BYTES) col_width = val;
    else if (idx == CFG_TARGET_SIGNED) col_signed = val[0];
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        resized_q.insert(resized_q.size(), resize_value(on_bus, col_width, col_signed));
        if ($urandom_range(0, 149) == 0) src_quiet <= !src_quiet;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (source_q.size() != 0) begin
          on_bus = source_q.pop_front();
          s_tdata <= {on_bus.slen, on_bus.hi, on_bus.lo};
          s_tuser <= on_bus.ssig;
          s_tvalid <= 1'b1;
          src_gap <= idle_len(src_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.status = status_t'(m_tuser[2:0]);
        seen.sgn = m_tuser[3];
        seen.lo = m_tdata[63:0];
        seen.hi = m_tdata[127:64];
        seen.len = m_tdata[132:128];
        if (resized_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d lo %h hi %h len %0d sgn %0b",
                     seen.status, seen.lo, seen.hi, seen.len, seen.sgn);
        end else begin
          want = resized_q.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch (exp/got): status %0d/%0d lo %h/%h hi %h/%h len %0d/%0d sgn %0b/%0b",
                       want.status, seen.status, want.lo, seen.lo, want.hi, seen.hi,
                       want.len, seen.len, want.sgn, seen.sgn);
          end
        end
        if ($urandom_range(0, 149) == 0) snk_quiet <= !snk_quiet;
      end
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) snk_gap <= idle_len(snk_quiet);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int p, i, r;
    logic [DECL_W-1:0] w;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    col_width = DECLARED_RESET;
    col_signed = TSIGNED_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset column: one signed byte
    push_source(64'h0, 64'h0, 8'd0, 1'b0);
    push_source(ONES64, ONES64, 8'd17, 1'b1);
    push_source(64'h0, 64'h0, 8'hFF, 1'b1);
    push_source(64'h7F, 64'h0, 8'd1, 1'b1);
    push_source(64'h80, 64'h0, 8'd1, 1'b0);
    push_source(64'hFFFF, 64'h0, 8'd2, 1'b1);
    push_source(64'h0180, 64'h0, 8'd2, 1'b1);
    push_source(64'hDEAD_BEEF_0000_0042, ONES64, 8'd1, 1'b0);
    settle();
    write_reg(CFG_DECLARED_BYTES, 16'd16);
    push_source(ONES64, ONES64, 8'd16, 1'b1);
    push_source(ONES64, ONES64, 8'd16, 1'b0);
    push_source(64'h80, ONES64, 8'd1, 1'b1);
    push_source(ONES64, 64'h7FFF_FFFF_FFFF_FFFF, 8'd16, 1'b0);
    push_source(64'h1234, 64'h0, 8'd3, 1'b0);
    settle();
    write_reg(CFG_TARGET_SIGNED, 16'hFFFE);
    write_reg(CFG_DECLARED_BYTES, 16'd4);
    push_source(64'hFF, 64'h0, 8'd1, 1'b1);
    push_source(64'h1_0000_0000, 64'h0, 8'd5, 1'b0);
    push_source(64'hFFFF_FFFF, 64'h0, 8'd8, 1'b0);
    push_source(64'h00FF_FFFF_FFFF, 64'h0, 8'd6, 1'b1);
    push_source(ONES64, ONES64, 8'd16, 1'b0);
    settle();
    // writes to unused indexes must leave the column alone
    write_reg(CFG_SPARE_IDX, 16'd0);
    write_reg(CFG_TOP_IDX, 16'hFFFF);
    push_source(64'h7F, 64'h0, 8'd1, 1'b0);
    settle();
    write_reg(CFG_DECLARED_BYTES, 16'd0);
    push_source(64'h1, 64'h0, 8'd1, 1'b0);
    settle();
    write_reg(CFG_DECLARED_BYTES, 16'd17);
    push_source(64'h1, 64'h0, 8'd1, 1'b1);
    settle();
    write_reg(CFG_DECLARED_BYTES, 16'hFFFF);
    push_source(64'h0, 64'h0, 8'd0, 1'b0);
    push_source(64'h1, 64'h0, 8'd1, 1'b0);

    for (p = 0; p < 14; p++) begin
      settle();
      r = $urandom_range(0, 9);
      if (p == 0) w = 16'd16;
      else if (p == 1) w = 16'd1;
      else if (r < 8) w = 16'($urandom_range(1, 16));
      else if (r == 8) w = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
      else w = 16'($urandom_range(17, 65535));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_DECLARED_BYTES, w);
        write_reg(CFG_TARGET_SIGNED, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(CFG_TARGET_SIGNED, 16'($urandom_range(0, 65535)));
        write_reg(CFG_DECLARED_BYTES, w);
      end
      for (i = 0; i < 125; i++)
        source_q.insert(source_q.size(), random_source());
    end

    settle();
    if (errors == 0 && resized_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> integer_width_normalizer.f
+incdir+sv
sv/iwn_pkg.sv
sv/iwn_lane.sv
sv/iwn_merge.sv
sv/integer_width_normalizer.sv
sim/tb.sv
